// ===== hdl/tevq_pkg.sv =====
// Package for the timed event queue: entry and control types, status codes,
// sequencer states and default sizes. No dependencies.
package tevq_pkg;

	// default number of cells in the event list
	localparam int DEPTH_DEF = 16;

	localparam int CH_W  = 8;
	localparam int DUE_W = 32;

	// result status codes
	typedef enum logic [1:0] {
		ST_QUEUED  = 2'd0,
		ST_DROPPED = 2'd1,
		ST_FIRED   = 2'd2,
		ST_NONE    = 2'd3
	} status_t;

	// input request kinds
	typedef enum logic {
		REQ_POST = 1'b0,
		REQ_TICK = 1'b1
	} req_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_SCAN  = 2'd1,
		S_FLUSH = 2'd2
	} state_t;

	// one stored event
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [DUE_W-1:0] due;
	} entry_t;

	// per-cycle control broadcast to every cell
	typedef struct packed {
		logic shift;
		logic wr;
	} cell_ctl_t;

endpackage

// ===== hdl/tevq_cell.sv =====
// One cell of the event list: holds a single entry, takes its right-hand
// neighbor on a shift or the broadcast entry when addressed. Uses tevq_pkg.
module tevq_cell #(
	parameter int IDX_W = 4,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  tevq_pkg::cell_ctl_t ctl,
	input  logic [IDX_W-1:0]    wr_addr,
	input  tevq_pkg::entry_t    wr_data,
	input  tevq_pkg::entry_t    nb,
	output tevq_pkg::entry_t    q
);
	import tevq_pkg::*;

	entry_t ent_q;
	logic   hit;

	assign hit = ctl.wr && (wr_addr == IDX_W'(IDX));

	// addressed write wins over the shift from the neighbor
	always_ff @(posedge clk) begin
		if (hit) begin
			ent_q <= wr_data;
		end else if (ctl.shift) begin
			ent_q <= nb;
		end
	end

	assign q = ent_q;

endmodule

// ===== hdl/timed_event_queue_top.sv =====
// Top level of the timed event queue: input/output streams, the sequencer and
// the row of tevq_cell list cells. Uses tevq_pkg.
//
// The block keeps up to DEPTH pending events in posting order in a row of
// cells that shift toward cell 0. A post is answered with queued or dropped.
// A tick on an empty list is answered at once with nothing due; otherwise
// the sequencer scans the stored events: while the output is not stalled,
// the entries pass one per cycle through the single due-time compare at the
// head cell, kept ones are written back at the tail so order is preserved,
// and the flush state then sends the last fired event (marked tlast) or a
// single nothing-due result. A stalled output holds the scan. The next input
// item is taken once the sequencer is back in idle and the output register
// is free or being emptied.
module timed_event_queue_top #(
	parameter int DEPTH = tevq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // channel_id[7:0], due_time[39:8], now_time[71:40]
	input  logic [0:0]  s_tuser,  // req_type[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // fired_channel[7:0], fired_due[39:8]
	output logic [1:0]  m_tuser,  // status[1:0]
	output logic        m_tlast
);
	import tevq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// input fields
	logic [CH_W-1:0]  in_ch;
	logic [DUE_W-1:0] in_due;
	logic [DUE_W-1:0] in_now;
	req_t             in_req;

	assign in_ch  = s_tdata[7:0];
	assign in_due = s_tdata[39:8];
	assign in_now = s_tdata[71:40];
	assign in_req = req_t'(s_tuser[0]);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_m1;
	logic [CNT_W-1:0] rem_q;
	logic [DUE_W-1:0] now_q;
	logic             pend_v_q;
	entry_t           pend_q;

	logic             out_valid_q;
	status_t          out_st_q;
	entry_t           out_ent_q;
	logic             out_last_q;

	// cell row
	entry_t           cell_q  [DEPTH];
	entry_t           cell_nb [DEPTH];
	cell_ctl_t        ctl;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	// datapath control
	logic    adv, accept, head_hit, full;
	logic    out_load;
	status_t out_load_st;
	entry_t  out_load_ent;
	logic    cnt_inc, cnt_dec;
	logic    tick_start, scan_step, pend_take;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && adv;
	assign accept   = s_tvalid && s_tready;
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign head_hit = (cell_q[0].due <= now_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && in_req == REQ_TICK && cnt_q != '0) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (adv && rem_q == CNT_W'(1)) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (adv) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		ctl          = '0;
		wr_addr      = cnt_q[IDX_W-1:0];
		wr_data      = '{ch: in_ch, due: in_due};
		out_load     = 1'b0;
		out_load_st  = ST_NONE;
		out_load_ent = '0;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		tick_start   = 1'b0;
		scan_step    = 1'b0;
		pend_take    = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (in_req == REQ_POST) begin
						out_load = 1'b1;
						if (full) begin
							out_load_st = ST_DROPPED;
						end else begin
							out_load_st = ST_QUEUED;
							ctl.wr      = 1'b1;
							cnt_inc     = 1'b1;
						end
					end else begin
						tick_start = 1'b1;
						if (cnt_q == '0) begin
							out_load    = 1'b1;
							out_load_st = ST_NONE;
						end
					end
				end
			end
			S_SCAN: begin
				if (adv) begin
					scan_step = 1'b1;
					ctl.shift = 1'b1;
					if (head_hit) begin
						cnt_dec   = 1'b1;
						pend_take = 1'b1;
						if (pend_v_q) begin
							out_load     = 1'b1;
							out_load_st  = ST_FIRED;
							out_load_ent = pend_q;
						end
					end else begin
						// kept entry goes back in at the tail
						ctl.wr  = 1'b1;
						wr_addr = cnt_m1[IDX_W-1:0];
						wr_data = cell_q[0];
					end
				end
			end
			S_FLUSH: begin
				if (adv) begin
					out_load = 1'b1;
					if (pend_v_q) begin
						out_load_st  = ST_FIRED;
						out_load_ent = pend_q;
					end else begin
						out_load_st = ST_NONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_m1;
			end
			if (tick_start) begin
				rem_q    <= cnt_q;
				pend_v_q <= 1'b0;
			end else begin
				if (scan_step) begin
					rem_q <= rem_q - CNT_W'(1);
				end
				if (pend_take) begin
					pend_v_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (tick_start) begin
			now_q <= in_now;
		end
		if (pend_take) begin
			pend_q <= cell_q[0];
		end
		if (out_load) begin
			out_st_q   <= out_load_st;
			out_ent_q  <= out_load_ent;
			out_last_q <= (state_q != S_SCAN);
		end
	end

	// row of list cells, each fed by its right-hand neighbor
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_end
			assign cell_nb[i] = cell_q[i];
		end else begin : g_mid
			assign cell_nb[i] = cell_q[i + 1];
		end
		tevq_cell #(
			.IDX_W (IDX_W),
			.IDX   (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.wr_addr (wr_addr),
			.wr_data (wr_data),
			.nb      (cell_nb[i]),
			.q       (cell_q[i])
		);
	end

	// output stream
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_ent_q.due, out_ent_q.ch};
	assign m_tuser  = out_st_q;
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("event count above list depth");

	a_scan_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> rem_q != '0)
		else $error("scan running with no entries left");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_FIRED |-> m_tdata == '0 && m_tlast)
		else $error("non-fired result with data or without last");

	a_busy_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> state_q == S_IDLE)
		else $error("input ready while a tick is in progress");
`endif

endmodule
